// ===== hdl/kfd_pkg.sv =====
`default_nettype none

package kfd_pkg;

    localparam int ROWS        = 5;
    localparam int COLUMNS     = 10;
    localparam int ROW_W       = COLUMNS;
    localparam int ROW_IDX_W   = $clog2(ROWS);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int CODE_W      = 6;
    localparam int LEN_W       = 8;
    localparam int ACTION_W    = 3;
    localparam int LAMP_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int SHIFT0_COL    = 2;
    localparam int SHIFT4_COL    = 7;
    localparam int SPACE_COL     = 9;
    localparam int BACKSPACE_COL = 0;
    localparam int POST_COL      = 6;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET  = 8'd140;
    localparam logic [LEN_W-1:0] WARN_LENGTH_RESET = 8'd100;

    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [CODE_W-1:0] code_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE   = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_FULL   = 3'd2,
        ACT_DELETE = 3'd3,
        ACT_POST   = 3'd4,
        ACT_EMPTY  = 3'd5
    } action_t;

    typedef enum logic [LAMP_W-1:0] {
        LAMP_GREEN  = 2'd0,
        LAMP_YELLOW = 2'd1,
        LAMP_RED    = 2'd2
    } lamp_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_LENGTH  = 2'd0,
        CFG_WARN_LENGTH = 2'd1
    } cfg_index_t;

    // lowest pressed column; zero when the row is empty
    function automatic col_t first_col(input row_t bits);
        col_t result;
        result = '0;
        for (int c = COLUMNS - 1; c >= 0; c--)
        begin
            if (bits[c])
            begin
                result = col_t'(c);
            end
        end
        return result;
    endfunction

    function automatic code_t key_code(input logic [ROW_IDX_W-1:0] r, input col_t c);
        return code_t'(r * COLUMNS) + code_t'(c);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/kfd_ifs.sv =====
`default_nettype none

interface kfd_frame_if;
    logic                 valid;
    logic                 ready;
    logic [kfd_pkg::ROW_W-1:0] row0_keys;
    logic [kfd_pkg::ROW_W-1:0] row1_keys;
    logic [kfd_pkg::ROW_W-1:0] row2_keys;
    logic [kfd_pkg::ROW_W-1:0] row3_keys;
    logic [kfd_pkg::ROW_W-1:0] row4_keys;

    modport source (output valid, row0_keys, row1_keys, row2_keys, row3_keys, row4_keys,
                    input ready);
    modport sink (input valid, row0_keys, row1_keys, row2_keys, row3_keys, row4_keys,
                  output ready);
endinterface

interface kfd_result_if;
    logic                         valid;
    logic                         ready;
    logic [kfd_pkg::ACTION_W-1:0] action;
    logic [kfd_pkg::CODE_W-1:0]   key_code;
    logic                         shifted;
    logic [kfd_pkg::LEN_W-1:0]    message_length;
    logic [kfd_pkg::LEN_W-1:0]    posted_length;
    logic [kfd_pkg::LAMP_W-1:0]   led_colour;

    modport source (output valid, action, key_code, shifted, message_length,
                    posted_length, led_colour, input ready);
    modport sink (input valid, action, key_code, shifted, message_length,
                  posted_length, led_colour, output ready);
endinterface

interface kfd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kfd_pkg::CFG_INDEX_W-1:0] index;
    logic [kfd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/key_frame_decoder_with_text_length.sv =====
// Channel   Dir  Word
// frame     in   five 10-bit rows of key contacts, one scan frame
// result    out  action, key_code, shifted, message_length, posted_length, led_colour
// cfg       in   index 0 max_length, index 1 warn_length; other indexes dropped
//
// One frame per cycle sustained while results are taken; a frame passes the frame
// register, then the result register, before its result is valid.
// Path: frame register -> priority decode + length/lamp update -> result register.
// Lock, length and lamp update when a frame moves into the result register.
// A stalled result holds; one more frame is still taken into an empty frame
// register, then frame.ready drops until the result is taken.
// Reset (rst_n low, async) clears lock, length, lamp and restores the config defaults.

`default_nettype none

module key_frame_decoder_with_text_length
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    kfd_frame_if.sink   frame,
    kfd_result_if.source result,
    kfd_cfg_if.sink     cfg
);
    import kfd_pkg::*;

    // ---------------- config registers
    len_t max_length_reg;
    len_t warn_length_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg  <= MAX_LENGTH_RESET;
            warn_length_reg <= WARN_LENGTH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MAX_LENGTH:  max_length_reg  <= cfg.data;
                CFG_WARN_LENGTH: warn_length_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- handshake control
    logic frame_valid_reg;
    logic result_valid_reg;
    logic out_free;
    logic advance;
    logic frame_take;

    assign out_free    = !result_valid_reg || result.ready;
    assign advance     = frame_valid_reg && out_free;
    assign frame.ready = !frame_valid_reg || out_free;
    assign frame_take  = frame.valid && frame.ready;

    // ---------------- frame register (payload, no reset)
    row_t rows_reg [ROWS];

    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            rows_reg[0] <= frame.row0_keys;
            rows_reg[1] <= frame.row1_keys;
            rows_reg[2] <= frame.row2_keys;
            rows_reg[3] <= frame.row3_keys;
            rows_reg[4] <= frame.row4_keys;
        end
    end

    // ---------------- block state
    logic  lock_reg;
    len_t  len_reg;
    lamp_t lamp_reg;

    logic    lock_next;
    len_t    len_next;
    lamp_t   lamp_next;
    action_t action_next;
    code_t   code_next;
    logic    shifted_next;
    len_t    posted_next;

    // ---------------- decode
    row_t eff [ROWS];
    row_t any_bits;
    logic any_key;
    logic found;
    code_t first_code;
    len_t  app_len;

    always_comb
    begin
        // shift positions never count as a key
        for (int r = 0; r < ROWS; r++)
        begin
            eff[r] = rows_reg[r];
        end
        eff[0][SHIFT0_COL]        = 1'b0;
        eff[ROWS-1][SHIFT4_COL]   = 1'b0;

        any_bits = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            any_bits = any_bits | eff[r];
        end
        any_key = |any_bits;

        // first row, then first column, with a non-shift key
        found      = 1'b0;
        first_code = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            if (!found && (|eff[r]))
            begin
                found      = 1'b1;
                first_code = key_code(ROW_IDX_W'(r), first_col(eff[r]));
            end
        end

        // append attempt, shared by the space and plain key paths
        app_len = (len_reg < max_length_reg) ? len_reg + 8'd1 : len_reg;

        lock_next    = lock_reg;
        len_next     = len_reg;
        lamp_next    = lamp_reg;
        action_next  = ACT_NONE;
        code_next    = '0;
        shifted_next = 1'b0;
        posted_next  = '0;

        if (!any_key)
        begin
            lock_next = 1'b0;
        end
        else if (!lock_reg)
        begin
            lock_next = 1'b1;
            if (rows_reg[0][SPACE_COL] || !(rows_reg[ROWS-1][BACKSPACE_COL]
                                            || rows_reg[ROWS-1][POST_COL]))
            begin
                // space: first non-shift column of row 0, never shifted
                if (rows_reg[0][SPACE_COL])
                begin
                    code_next = code_t'(first_col(eff[0]));
                end
                else
                begin
                    code_next    = first_code;
                    shifted_next = rows_reg[0][SHIFT0_COL] | rows_reg[ROWS-1][SHIFT4_COL];
                end
                action_next = (len_reg < max_length_reg) ? ACT_APPEND : ACT_FULL;
                len_next    = app_len;
                if (app_len == max_length_reg)
                begin
                    lamp_next = LAMP_RED;
                end
                else if (app_len > warn_length_reg)
                begin
                    lamp_next = LAMP_YELLOW;
                end
            end
            else if (rows_reg[ROWS-1][BACKSPACE_COL])
            begin
                action_next = ACT_DELETE;
                if (len_reg != '0)
                begin
                    len_next = len_reg - 8'd1;
                end
            end
            else
            begin
                // post
                lamp_next = LAMP_GREEN;
                if (len_reg == '0)
                begin
                    action_next = ACT_EMPTY;
                end
                else
                begin
                    action_next = ACT_POST;
                    posted_next = len_reg;
                    len_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            lock_reg         <= 1'b0;
            len_reg          <= '0;
            lamp_reg         <= LAMP_GREEN;
        end
        else
        begin
            if (frame_take)
            begin
                frame_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                frame_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
                lock_reg         <= lock_next;
                len_reg          <= len_next;
                lamp_reg         <= lamp_next;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- result register (payload, no reset)
    action_t action_reg;
    code_t   code_reg;
    logic    shifted_reg;
    len_t    msg_len_reg;
    len_t    posted_reg;
    lamp_t   led_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            action_reg  <= action_next;
            code_reg    <= code_next;
            shifted_reg <= shifted_next;
            msg_len_reg <= len_next;
            posted_reg  <= posted_next;
            led_reg     <= lamp_next;
        end
    end

    assign result.valid          = result_valid_reg;
    assign result.action         = action_reg;
    assign result.key_code       = code_reg;
    assign result.shifted        = shifted_reg;
    assign result.message_length = msg_len_reg;
    assign result.posted_length  = posted_reg;
    assign result.led_colour     = led_reg;

`ifndef SYNTHESIS
    // a successful post empties the message and greens the lamp
    a_post_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && action_reg == ACT_POST)
        |-> (msg_len_reg == '0 && led_reg == LAMP_GREEN && posted_reg != '0))
        else $error("post did not clear message");

    // an accepted append never overruns the limit
    a_append_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && action_reg == ACT_APPEND)
        |-> (msg_len_reg <= max_length_reg && msg_len_reg != '0))
        else $error("append past max_length");

    // no action (idle or locked frame), no side payload
    a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && action_reg == ACT_NONE)
        |-> (code_reg == '0 && !shifted_reg && posted_reg == '0))
        else $error("idle frame carries payload");

    // any decoded action leaves the lock set
    a_lock_set: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && action_next != ACT_NONE) |=> lock_reg)
        else $error("lock not set after decode");
`endif

endmodule

`default_nettype wire

// ===== sim/key_frame_checker.sv =====
`timescale 1ns / 1ps

// Watches all three channels, keeps its own copy of lock/length/lamp state and
// the two length registers, and checks each result word against the oldest
// predicted word.
module key_frame_checker
(
    input  wire logic clk,
    input  wire logic rst_n,
    kfd_frame_if      frame,
    kfd_result_if     result,
    kfd_cfg_if        cfg,
    output int        fail_count,
    output int        pending
);
    import kfd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef logic [ROWS-1:0][ROW_W-1:0] scan_t;

    typedef struct packed {
        action_t action;
        code_t   key_code;
        logic    shifted;
        len_t    message_length;
        len_t    posted_length;
        lamp_t   led_colour;
    } outcome_t;

    outcome_t expected_words[$];

    logic  key_lock;
    len_t  text_len;
    lamp_t lamp;
    len_t  max_len;
    len_t  warn_len;
    int    mismatches;
    int    result_idx;

    function automatic int lowest_pressed(input row_t bits);
        for (int c = 0; c < COLUMNS; c++)
        begin
            if (bits[c])
            begin
                return c;
            end
        end
        return 0;
    endfunction

    // append if room is left, then the lamp check on the resulting length
    function automatic action_t append_char();
        action_t act;
        act = ACT_FULL;
        if (text_len < max_len)
        begin
            text_len = text_len + 8'd1;
            act = ACT_APPEND;
        end
        if (text_len == max_len)
        begin
            lamp = LAMP_RED;
        end
        else if (text_len > warn_len)
        begin
            lamp = LAMP_YELLOW;
        end
        return act;
    endfunction

    function automatic outcome_t decode_scan(input scan_t rows);
        scan_t    keys;
        row_t     any_key;
        outcome_t o;
        o.action         = ACT_NONE;
        o.key_code       = '0;
        o.shifted        = 1'b0;
        o.posted_length  = '0;
        keys = rows;
        keys[0][SHIFT0_COL]      = 1'b0;
        keys[ROWS-1][SHIFT4_COL] = 1'b0;
        any_key = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            any_key = any_key | keys[r];
        end
        if (any_key == '0)
        begin
            key_lock = 1'b0;
        end
        else if (!key_lock)
        begin
            key_lock = 1'b1;
            if (rows[0][SPACE_COL])
            begin
                // space path takes the lowest non-shift column of row 0, never shifted
                o.key_code = code_t'(lowest_pressed(keys[0]));
                o.action   = append_char();
            end
            else if (rows[ROWS-1][BACKSPACE_COL])
            begin
                if (text_len != 0)
                begin
                    text_len = text_len - 8'd1;
                end
                o.action = ACT_DELETE;
            end
            else if (rows[ROWS-1][POST_COL])
            begin
                if (text_len == 0)
                begin
                    o.action = ACT_EMPTY;
                end
                else
                begin
                    o.posted_length = text_len;
                    text_len        = '0;
                    o.action        = ACT_POST;
                end
                lamp = LAMP_GREEN;
            end
            else
            begin
                o.shifted = rows[0][SHIFT0_COL] | rows[ROWS-1][SHIFT4_COL];
                for (int r = ROWS - 1; r >= 0; r--)
                begin
                    if (keys[r] != '0)
                    begin
                        o.key_code = code_t'(r * COLUMNS + lowest_pressed(keys[r]));
                    end
                end
                o.action = append_char();
            end
        end
        o.message_length = text_len;
        o.led_colour     = lamp;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            expected_words.delete();
            key_lock   = 1'b0;
            text_len   = '0;
            lamp       = LAMP_GREEN;
            max_len    = MAX_LENGTH_RESET;
            warn_len   = WARN_LENGTH_RESET;
            mismatches = 0;
            result_idx = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_MAX_LENGTH)
                begin
                    max_len = cfg.data;
                end
                else if (cfg.index == CFG_WARN_LENGTH)
                begin
                    warn_len = cfg.data;
                end
            end
            // results always trail their frame, so pop first
            if (result.valid && result.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display("result word %0d arrived with nothing expected", result_idx);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (result.action !== want.action || result.key_code !== want.key_code ||
                        result.shifted !== want.shifted ||
                        result.message_length !== want.message_length ||
                        result.posted_length !== want.posted_length ||
                        result.led_colour !== want.led_colour)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $display("result word %0d mismatch", result_idx);
                            $display("  exp act=%0d code=%0d sh=%0d len=%0d post=%0d led=%0d",
                                     want.action, want.key_code, want.shifted,
                                     want.message_length, want.posted_length, want.led_colour);
                            $display("  got act=%0d code=%0d sh=%0d len=%0d post=%0d led=%0d",
                                     result.action, result.key_code, result.shifted,
                                     result.message_length, result.posted_length,
                                     result.led_colour);
                        end
                        mismatches++;
                    end
                end
                result_idx++;
            end
            if (frame.valid && frame.ready)
            begin
                expected_words.push_back(decode_scan({frame.row4_keys, frame.row3_keys,
                                                      frame.row2_keys, frame.row1_keys,
                                                      frame.row0_keys}));
            end
        end
        fail_count <= mismatches;
        pending    <= expected_words.size();
    end

endmodule

// ===== sim/key_frame_decoder_with_text_length_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the key frame decoder. Prediction and checking
// live in key_frame_checker; this module only drives words and waits.
module key_frame_decoder_with_text_length_tb;
    import kfd_pkg::*;

    typedef logic [ROWS-1:0][ROW_W-1:0] scan_t;

    // cycles with no word moving on any channel before the run is called dead
    localparam int STALL_LIMIT = 2000;
    // wait after the last predicted result word has come back; leave some margin
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;
    logic calm;          // set for the closing stretch: no gaps, no stalls
    int   fail_count;
    int   pending;       // predicted result words not yet seen
    int   idle_cycles;

    kfd_frame_if  frame();
    kfd_result_if result();
    kfd_cfg_if    cfg();

    key_frame_decoder_with_text_length u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame),
        .result (result),
        .cfg    (cfg)
    );

    key_frame_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .result     (result),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: ready drops in random bursts, otherwise stays high.
    initial
    begin
        int hold;
        hold = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!calm && hold == 0 && $urandom_range(0, 9) == 0)
            begin
                hold = $urandom_range(1, 10);
            end
            if (hold > 0)
            begin
                result.ready <= 1'b0;
                hold--;
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    // Watchdog: any word moving on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (frame.valid && frame.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one contact closed
    function automatic scan_t key_at(input int r, input int c);
        scan_t s;
        s = '0;
        s[r][c] = 1'b1;
        return s;
    endfunction

    // a single non-shift key, optionally with either or both shift keys held
    function automatic scan_t one_key(input bit with_shift);
        scan_t s;
        int    r;
        int    c;
        r = $urandom_range(0, ROWS - 1);
        c = $urandom_range(0, COLUMNS - 1);
        if ((r == 0 && c == SHIFT0_COL) || (r == ROWS - 1 && c == SHIFT4_COL))
        begin
            c = c + 1;
        end
        s = key_at(r, c);
        if (with_shift)
        begin
            s[0][SHIFT0_COL]      = 1'($urandom_range(0, 1));
            s[ROWS-1][SHIFT4_COL] = 1'($urandom_range(0, 1));
        end
        return s;
    endfunction

    // Drive one frame word and hold it until accepted. An optional gap
    // goes in front. Valid stays high on return so back-to-back
    // words need no extra assignment.
    task automatic send_scan(input scan_t s);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            frame.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        frame.valid     <= 1'b1;
        frame.row0_keys <= s[0];
        frame.row1_keys <= s[1];
        frame.row2_keys <= s[2];
        frame.row3_keys <= s[3];
        frame.row4_keys <= s[4];
        do @(posedge clk); while (!frame.ready);
    endtask

    // press, then release
    task automatic tap(input scan_t s);
        send_scan(s);
        send_scan('0);
    endtask

    // Stop sending and let every predicted result word come back.
    task automatic settle();
        frame.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Both length registers in one burst; valid stays high between the two words.
    task automatic set_lengths(input len_t max_value, input len_t warn_value);
        settle();
        cfg.valid <= 1'b1;
        cfg.index <= CFG_MAX_LENGTH;
        cfg.data  <= max_value;
        do @(posedge clk); while (!cfg.ready);
        cfg.index <= CFG_WARN_LENGTH;
        cfg.data  <= warn_value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Keystrokes: a press frame, sometimes held for a second (locked) frame,
    // then a release frame that may still carry shift keys. With grow_only
    // set, backspace and post contacts are removed so the message only grows.
    task automatic random_typing(input int presses, input bit grow_only);
        scan_t press_s;
        scan_t release_s;
        int    pick;
        for (int i = 0; i < presses; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                press_s = one_key(1'b1);
            end
            else if (pick < 62)
            begin
                press_s = key_at(0, SPACE_COL);
                if ($urandom_range(0, 3) == 0)
                begin
                    press_s[0] = press_s[0] | row_t'($urandom_range(0, 1023));
                end
            end
            else if (pick < 70)
            begin
                press_s = key_at(ROWS - 1, BACKSPACE_COL);
                if ($urandom_range(0, 3) == 0)
                begin
                    press_s = press_s | one_key(1'b1);
                end
            end
            else if (pick < 75)
            begin
                press_s = key_at(ROWS - 1, POST_COL);
            end
            else if (pick < 88)
            begin
                press_s = one_key(1'b1) | one_key(1'b0) | one_key(1'b0);
            end
            else
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    press_s[r] = row_t'($urandom_range(0, 1023));
                end
            end
            if (grow_only)
            begin
                press_s[ROWS-1][BACKSPACE_COL] = 1'b0;
                press_s[ROWS-1][POST_COL]      = 1'b0;
            end
            send_scan(press_s);
            if ($urandom_range(0, 9) == 0)
            begin
                send_scan(press_s);
            end
            release_s = '0;
            if ($urandom_range(0, 4) == 0)
            begin
                release_s[0][SHIFT0_COL]      = 1'($urandom_range(0, 1));
                release_s[ROWS-1][SHIFT4_COL] = 1'($urandom_range(0, 1));
            end
            send_scan(release_s);
        end
    endtask

    initial
    begin
        scan_t held;
        calm            = 1'b0;
        rst_n          <= 1'b0;
        frame.valid    <= 1'b0;
        frame.row0_keys <= '0;
        frame.row1_keys <= '0;
        frame.row2_keys <= '0;
        frame.row3_keys <= '0;
        frame.row4_keys <= '0;
        cfg.valid      <= 1'b0;
        cfg.index      <= CFG_MAX_LENGTH;
        cfg.data       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed frames, reset lengths (140 / 100) ----
        send_scan('0);
        // every contact closed: space wins, appends row 0 column 0 unshifted
        tap('1);
        tap(key_at(0, SPACE_COL));
        // space with shift held still appends column 9 unshifted
        tap(key_at(0, SPACE_COL) | key_at(0, SHIFT0_COL));
        // both shift keys alone count as no key: releases the lock
        send_scan(key_at(0, SHIFT0_COL) | key_at(ROWS - 1, SHIFT4_COL));
        // shifted key, then the same frame again while locked: no action
        held = key_at(2, 3) | key_at(ROWS - 1, SHIFT4_COL);
        send_scan(held);
        send_scan(held);
        send_scan('0);
        // highest key code, then first-row-first ordering across rows
        tap(key_at(ROWS - 1, COLUMNS - 1));
        tap(key_at(3, COLUMNS - 1) | key_at(1, 0) | key_at(ROWS - 1, 1));
        tap(key_at(ROWS - 1, BACKSPACE_COL));
        // backspace outranks post, space outranks backspace
        tap(key_at(ROWS - 1, BACKSPACE_COL) | key_at(ROWS - 1, POST_COL));
        tap(key_at(0, SPACE_COL) | key_at(ROWS - 1, BACKSPACE_COL));
        tap(key_at(ROWS - 1, POST_COL));
        // post and delete on an empty message
        tap(key_at(ROWS - 1, POST_COL));
        tap(key_at(ROWS - 1, BACKSPACE_COL));

        // ---- short message: fill to the top, red lamp, refused appends ----
        set_lengths(8'd5, 8'd2);
        random_typing(30, 1'b1);
        // limit lowered under the current length: refused, yellow above warn
        set_lengths(8'd3, 8'd0);
        random_typing(10, 1'b1);
        random_typing(20, 1'b0);
        // zero limit: nothing fits, empty message shows red
        set_lengths(8'd0, 8'd255);
        random_typing(30, 1'b0);
        // widest limit, grown all the way to 255 characters
        set_lengths(8'd255, 8'd255);
        random_typing(290, 1'b1);
        set_lengths(8'd255, 8'd0);
        random_typing(40, 1'b0);
        set_lengths(8'd1, 8'd0);
        random_typing(40, 1'b0);
        for (int p = 0; p < 3; p++)
        begin
            set_lengths(len_t'($urandom_range(1, 255)), len_t'($urandom_range(0, 255)));
            random_typing(40, 1'b0);
        end

        // ---- closing stretch at reset values, both sides flat out ----
        set_lengths(MAX_LENGTH_RESET, WARN_LENGTH_RESET);
        calm = 1'b1;
        random_typing(60, 1'b0);

        frame.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
